// ===== src/pap_pkg.sv =====
package pap_pkg;

   // fixed-point layout of the log domain
   localparam int LOG_FRAC = 24;
   localparam int LOG_W = 30;
   localparam int MANT_W = 31;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLATILITY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIKE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CARRY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_CALL = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   typedef logic [MANT_W-1:0] mant_type;
   typedef logic [LOG_W-1:0] log_type;

   typedef struct packed {
      logic [5:0] pos;
      mant_type   mant;
   } norm_type;

   typedef struct packed {
      mant_type mant;
      logic     hit;
   } step_type;

   // constants derived from the configuration, handed to the datapath
   typedef struct packed {
      logic               busy;
      logic               cfg_bad;
      logic               call_mode;
      logic               call_bad;
      logic               y_zero;
      logic               clamp;
      logic [31:0]        strike;
      logic [31:0]        y_abs;
      logic signed [32:0] d_const;
      logic signed [32:0] l_const;
   } setup_type;

   // leading-one position and Q30 mantissa of a nonzero value
   function automatic norm_type log_norm(input logic [32:0] x);
      norm_type   res;
      logic [5:0] pos;
      logic [32:0] sh;
      pos = '0;
      for (int i = 0; i < 33; i++) begin
         if (x[i]) pos = 6'(i);
      end
      if (pos >= 6'd30) begin
         sh = x >> (pos - 6'd30);
      end else begin
         sh = x << (6'd30 - pos);
      end
      res.pos = pos;
      res.mant = sh[MANT_W-1:0];
      return res;
   endfunction

   // one squaring step of the log2 fraction
   function automatic step_type log_step(input mant_type m);
      logic [2*MANT_W-1:0] sq;
      logic [31:0]         t;
      step_type            res;
      sq = (2*MANT_W)'(m) * (2*MANT_W)'(m);
      t = sq[61:30];
      if (t[31]) begin
         res.mant = t[31:1];
         res.hit = 1'b1;
      end else begin
         res.mant = t[30:0];
         res.hit = 1'b0;
      end
      return res;
   endfunction

   // Q30 factor 2^(2^-step) from repeated floor square roots of 2.0
   function automatic mant_type exp_factor(input int step);
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      s = 64'd1 << 31;
      for (int i = 1; i <= step; i++) begin
         v = s << 30;
         r = '0;
         b = 64'd1 << 62;
         for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         s = r;
      end
      return s[MANT_W-1:0];
   endfunction

endpackage

// ===== src/pap_setup.sv =====
module pap_setup #(
   parameter int FRAC_BITS = 16,
   parameter int APPROX_ITERATIONS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pap_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pap_pkg::setup_type                setup
);
   import pap_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_DIVA  = 4'd2;
   localparam logic [3:0] ST_DIVC  = 4'd3;
   localparam logic [3:0] ST_DABS  = 4'd4;
   localparam logic [3:0] ST_SQR   = 4'd5;
   localparam logic [3:0] ST_RSUM  = 4'd6;
   localparam logic [3:0] ST_ROOT  = 4'd7;
   localparam logic [3:0] ST_Y     = 4'd8;
   localparam logic [3:0] ST_ND    = 4'd9;
   localparam logic [3:0] ST_LNORM = 4'd10;
   localparam logic [3:0] ST_LSQ   = 4'd11;
   localparam logic [3:0] ST_FIN   = 4'd12;

   localparam logic [5:0] DIV_LAST = 6'd49;
   localparam logic [5:0] ROOT_LAST = 6'd31;
   localparam logic [5:0] LOG_LAST = 6'(APPROX_ITERATIONS - 1);
   localparam logic [49:0] A_LIMIT = 50'd1 << 30;
   localparam logic signed [34:0] Y_MAX = 35'sd2147483648;
   localparam logic signed [34:0] Y_MIN = -35'sd2147483648;
   localparam logic signed [32:0] FB_LOG = 33'(FRAC_BITS) << LOG_FRAC;
   localparam logic signed [32:0] Q16_LOG = 33'(16) << LOG_FRAC;

   // configuration registers
   logic [15:0] rate_ff, vol_ff;
   logic [31:0] strike_ff;
   logic [16:0] carry_ff;
   logic        call_ff;

   // sequencer registers
   logic [3:0]  state_ff, state_in;
   logic [31:0] s2_ff, s2_in;
   logic        bneg_ff, bneg_in;
   logic [49:0] dq_ff, dq_in;
   logic [31:0] dr_ff, dr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [31:0] a_ff, a_in;
   logic [30:0] c_ff, c_in;
   logic        clamp_ff, clamp_in;
   logic [30:0] dabs_ff, dabs_in;
   logic [61:0] sq_ff, sq_in;
   logic [62:0] rv_ff, rv_in, rr_ff, rr_in, rb_ff, rb_in;
   logic signed [32:0] y_ff, y_in;
   logic [32:0] num_ff, num_in, den_ff, den_in;
   logic [1:0]  lsel_ff, lsel_in;
   mant_type    lm_ff, lm_in;
   logic [5:0]  lp_ff, lp_in;
   logic [23:0] lf_ff, lf_in;
   log_type     lk_ff, lk_in, ln_ff, ln_in, ld_ff, ld_in;
   logic signed [32:0] dc_ff, dc_in, lc_ff, lc_in;

   // combinational helpers
   logic [32:0] rs;
   logic        ge;
   logic [49:0] q_next;
   logic [49:0] q_sat;
   logic        q_over;
   logic [16:0] babs;
   logic signed [32:0] d_off;
   logic [62:0] rt_sum;
   logic signed [34:0] y_base, y_raw;
   logic [32:0] lx;
   norm_type    nrm;
   step_type    stp;
   log_type     lres;
   logic signed [32:0] y_neg;

   // register writes from the port
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 16'd3277;
         vol_ff <= 16'd13107;
         strike_ff <= 32'd6553600;
         carry_ff <= 17'd3277;
         call_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:       rate_ff <= csr_wdata[15:0];
            CSR_VOLATILITY: vol_ff <= csr_wdata[15:0];
            CSR_STRIKE:     strike_ff <= csr_wdata[31:0];
            CSR_CARRY:      carry_ff <= csr_wdata[16:0];
            CSR_IS_CALL:    call_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // shared datapath pieces
   always_comb begin
      rs = {dr_ff, dq_ff[49]};
      ge = rs >= {1'b0, s2_ff};
      q_next = {dq_ff[48:0], ge};
      q_over = q_next > A_LIMIT;
      q_sat = q_over ? A_LIMIT : q_next;
      babs = carry_ff[16] ? 17'(~carry_ff + 17'd1) : carry_ff;
      d_off = 33'(a_ff) - 33'sd32768;
      rt_sum = rr_ff + rb_ff;
      y_base = 35'sd32768 - 35'(a_ff);
      y_raw = call_ff ? (y_base + $signed({3'b0, rr_ff[31:0]}))
                      : (y_base - $signed({3'b0, rr_ff[31:0]}));
      y_neg = -y_ff;
      case (lsel_ff)
         2'd0:    lx = {1'b0, strike_ff};
         2'd1:    lx = num_ff;
         default: lx = den_ff;
      endcase
      nrm = log_norm(lx);
      stp = log_step(lm_ff);
   end

   // setup sequencer
   always_comb begin
      state_in = state_ff;
      s2_in = s2_ff;
      bneg_in = bneg_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      c_in = c_ff;
      clamp_in = clamp_ff;
      dabs_in = dabs_ff;
      sq_in = sq_ff;
      rv_in = rv_ff;
      rr_in = rr_ff;
      rb_in = rb_ff;
      y_in = y_ff;
      num_in = num_ff;
      den_in = den_ff;
      lsel_in = lsel_ff;
      lm_in = lm_ff;
      lp_in = lp_ff;
      lf_in = lf_ff;
      lk_in = lk_ff;
      ln_in = ln_ff;
      ld_in = ld_ff;
      dc_in = dc_ff;
      lc_in = lc_ff;
      lres = {lp_ff, lf_ff};
      case (state_ff)
         ST_IDLE: ;
         ST_START: begin
            s2_in = 32'(vol_ff) * 32'(vol_ff);
            bneg_in = carry_ff[16];
            dq_in = {1'b0, babs, 32'd0};
            dr_in = '0;
            cnt_in = '0;
            clamp_in = 1'b0;
            state_in = ST_DIVA;
         end
         ST_DIVA, ST_DIVC: begin
            dq_in = q_next;
            dr_in = ge ? 32'(rs - {1'b0, s2_ff}) : rs[31:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               clamp_in = clamp_ff | q_over;
               cnt_in = '0;
               dr_in = '0;
               if (state_ff == ST_DIVA) begin
                  a_in = bneg_ff ? -$signed(q_sat[31:0]) : $signed(q_sat[31:0]);
                  dq_in = {1'b0, rate_ff, 33'd0};
                  state_in = ST_DIVC;
               end else begin
                  c_in = q_sat[30:0];
                  state_in = ST_DABS;
               end
            end
         end
         ST_DABS: begin
            dabs_in = d_off[32] ? 31'(-d_off) : d_off[30:0];
            state_in = ST_SQR;
         end
         ST_SQR: begin
            sq_in = 62'(dabs_ff) * 62'(dabs_ff);
            state_in = ST_RSUM;
         end
         ST_RSUM: begin
            rv_in = {1'b0, sq_ff} + (63'(c_ff) << 16);
            rr_in = '0;
            rb_in = 63'd1 << 62;
            cnt_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (rv_ff >= rt_sum) begin
               rv_in = rv_ff - rt_sum;
               rr_in = (rr_ff >> 1) + rb_ff;
            end else begin
               rr_in = rr_ff >> 1;
            end
            rb_in = rb_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == ROOT_LAST) state_in = ST_Y;
         end
         ST_Y: begin
            if (y_raw > Y_MAX) begin
               y_in = 33'(Y_MAX);
               clamp_in = 1'b1;
            end else if (y_raw < Y_MIN) begin
               y_in = 33'(Y_MIN);
               clamp_in = 1'b1;
            end else begin
               y_in = 33'(y_raw);
            end
            state_in = ST_ND;
         end
         ST_ND: begin
            if (call_ff) begin
               num_in = 33'(y_ff - 33'sd65536);
               den_in = 33'(y_ff);
            end else begin
               den_in = 33'(y_neg);
               num_in = 33'(y_neg) + 33'd65536;
            end
            lsel_in = '0;
            state_in = ST_LNORM;
         end
         ST_LNORM: begin
            lm_in = nrm.mant;
            lp_in = nrm.pos;
            lf_in = '0;
            cnt_in = '0;
            state_in = ST_LSQ;
         end
         ST_LSQ: begin
            lm_in = stp.mant;
            if (stp.hit && cnt_ff < 6'd24) begin
               lf_in = lf_ff | (24'd1 << (5'd23 - cnt_ff[4:0]));
            end
            cnt_in = cnt_ff + 6'd1;
            lres = {lp_ff, lf_in};
            if (cnt_ff == LOG_LAST) begin
               case (lsel_ff)
                  2'd0:    lk_in = lres;
                  2'd1:    ln_in = lres;
                  default: ld_in = lres;
               endcase
               lsel_in = lsel_ff + 2'd1;
               state_in = (lsel_ff == 2'd2) ? ST_FIN : ST_LNORM;
            end
         end
         ST_FIN: begin
            dc_in = $signed({3'b0, ln_ff}) - $signed({3'b0, ld_ff})
                  - $signed({3'b0, lk_ff});
            lc_in = $signed({3'b0, lk_ff}) - FB_LOG - $signed({3'b0, ln_ff}) + Q16_LOG;
            state_in = ST_IDLE;
         end
         default: state_in = ST_START;
      endcase
      // any register write restarts the derivation
      if (csr_we) state_in = ST_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      bneg_ff <= bneg_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      c_ff <= c_in;
      clamp_ff <= clamp_in;
      dabs_ff <= dabs_in;
      sq_ff <= sq_in;
      rv_ff <= rv_in;
      rr_ff <= rr_in;
      rb_ff <= rb_in;
      y_ff <= y_in;
      num_ff <= num_in;
      den_ff <= den_in;
      lsel_ff <= lsel_in;
      lm_ff <= lm_in;
      lp_ff <= lp_in;
      lf_ff <= lf_in;
      lk_ff <= lk_in;
      ln_ff <= ln_in;
      ld_ff <= ld_in;
      dc_ff <= dc_in;
      lc_ff <= lc_in;
   end

   // constants for the per-request datapath
   always_comb begin
      setup.busy = state_ff != ST_IDLE;
      setup.cfg_bad = (vol_ff == 16'd0) || (strike_ff == 32'd0);
      setup.call_mode = call_ff;
      setup.call_bad = call_ff && (y_ff <= 33'sd65536);
      setup.y_zero = y_ff == 33'sd0;
      setup.clamp = clamp_ff;
      setup.strike = strike_ff;
      setup.y_abs = call_ff ? y_ff[31:0] : y_neg[31:0];
      setup.d_const = dc_ff;
      setup.l_const = lc_ff;
   end

endmodule

// ===== src/perpetual_american_option_price.sv =====
// Perpetual American option pricer, closed form, Q16.16 in and out.
// Request channel: req_valid/req_ready with req_underlying_q16 (price U).
// Response channel: rsp_valid/rsp_ready with rsp_price_q16 and rsp_status
// (0 ok, 1 invalid configuration, exponent or zero base, 2 saturated or clamped).
// Registers are written through csr_we/csr_index/csr_wdata, index order:
// rate, volatility, strike, carry, is_call.
// Throughput: one request per cycle once set up, while no held response stalls the pipeline.
// Pipeline stages from the accepting edge to rsp_valid, in order: input and
// normalize registers, one log2 squaring stage per iteration for U, three
// stages for the log difference, the product and the exponent, one exp2
// multiply stage per fraction bit (min(APPROX_ITERATIONS, 24) of them),
// then the response register.
// After reset and after every register write, a serial setup unit derives
// the exponent and log constants (two 50-step divides, a 32-step root and
// three log2 runs); req_ready stays low during that time. Reset also
// empties the pipeline.
// When rsp_ready is low with a response waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
module perpetual_american_option_price #(
   parameter int FRAC_BITS = 16,
   parameter int APPROX_ITERATIONS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_underlying_q16,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_price_q16,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [pap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pap_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pap_pkg::*;

   localparam int EXP_STEPS = (APPROX_ITERATIONS < LOG_FRAC) ? APPROX_ITERATIONS : LOG_FRAC;
   localparam int LAST = APPROX_ITERATIONS + 4 + EXP_STEPS;
   localparam logic signed [25:0] FB_S = 26'(FRAC_BITS);

   setup_type setup;

   logic en;
   logic [LAST:0] vld_ff, uz_ff;
   logic [31:0] u_ff;
   mant_type    lg_m_ff [0:APPROX_ITERATIONS];
   logic [5:0]  lg_p_ff [0:APPROX_ITERATIONS];
   logic [23:0] lg_f_ff [0:APPROX_ITERATIONS];
   logic [31:0] d_abs_ff, d_abs_in;
   logic        d_neg_ff;
   logic [63:0] prod_ff, prod_in;
   logic        p_neg_ff, p_neg_in;
   logic signed [47:0] ex_l_ff [0:EXP_STEPS];
   mant_type    ex_acc_ff [0:EXP_STEPS];
   logic signed [47:0] l_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_price_ff, rsp_price_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   norm_type    nrm;
   log_type     lu;
   logic signed [33:0] dsum;
   logic signed [63:0] sp;
   logic signed [23:0] n_int;
   logic signed [25:0] nf, sh;
   logic        sat;
   logic [31:0] exp_p;
   mant_type    acc_last;

   pap_setup #(
      .FRAC_BITS(FRAC_BITS),
      .APPROX_ITERATIONS(APPROX_ITERATIONS)
   ) u_setup (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .setup(setup)
   );

   // pipeline advances unless a response is held
   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !setup.busy && !csr_we;

   // valid bits and zero-underlying flags
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid && req_ready};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         uz_ff <= {uz_ff[LAST-1:0], req_underlying_q16 == 32'd0};
         u_ff <= req_underlying_q16;
      end
   end

   // normalize U for log2
   assign nrm = log_norm({1'b0, u_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         lg_m_ff[0] <= nrm.mant;
         lg_p_ff[0] <= nrm.pos;
         lg_f_ff[0] <= '0;
      end
   end

   // log2 squaring stages
   for (genvar k = 1; k <= APPROX_ITERATIONS; k++) begin : g_log
      step_type    stp;
      logic [23:0] f_in;
      always_comb begin
         stp = log_step(lg_m_ff[k-1]);
         f_in = lg_f_ff[k-1];
         if (k <= LOG_FRAC && stp.hit) begin
            f_in = lg_f_ff[k-1] | (24'd1 << (LOG_FRAC - ((k <= LOG_FRAC) ? k : LOG_FRAC)));
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            lg_m_ff[k] <= stp.mant;
            lg_p_ff[k] <= lg_p_ff[k-1];
            lg_f_ff[k] <= f_in;
         end
      end
   end

   // log difference, its magnitude and sign
   always_comb begin
      lu = {lg_p_ff[APPROX_ITERATIONS], lg_f_ff[APPROX_ITERATIONS]};
      dsum = 34'(setup.d_const) + $signed({4'b0, lu});
      d_abs_in = dsum[33] ? 32'(-dsum) : dsum[31:0];
   end

   // y times log difference
   assign prod_in = 64'(d_abs_ff) * 64'(setup.y_abs);
   assign p_neg_in = d_neg_ff ^ !setup.call_mode;

   // exponent of the result in Q24
   always_comb begin
      sp = p_neg_ff ? -$signed(prod_ff) : $signed(prod_ff);
      l_in = 48'(setup.l_const) + 48'(sp >>> 16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_abs_ff <= d_abs_in;
         d_neg_ff <= dsum[33];
         prod_ff <= prod_in;
         p_neg_ff <= p_neg_in;
         ex_l_ff[0] <= l_in;
         ex_acc_ff[0] <= mant_type'(1) << 30;
      end
   end

   // exp2 multiply stages, one fraction bit each
   for (genvar j = 1; j <= EXP_STEPS; j++) begin : g_exp
      localparam mant_type FACT = exp_factor(j);
      logic [2*MANT_W-1:0] mul;
      mant_type            acc_in;
      always_comb begin
         mul = (2*MANT_W)'(ex_acc_ff[j-1]) * (2*MANT_W)'(FACT);
         acc_in = ex_l_ff[j-1][LOG_FRAC-j] ? mul[60:30] : ex_acc_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ex_acc_ff[j] <= acc_in;
            ex_l_ff[j] <= ex_l_ff[j-1];
         end
      end
   end

   // final scaling, saturation and special cases
   always_comb begin
      acc_last = ex_acc_ff[EXP_STEPS];
      n_int = ex_l_ff[EXP_STEPS][47:24];
      nf = 26'(n_int) + FB_S;
      sat = nf >= 26'sd32;
      sh = 26'sd30 - nf;
      if (sat) begin
         exp_p = 32'hFFFF_FFFF;
      end else if (nf >= 26'sd30) begin
         exp_p = 32'(acc_last) << nf[0];
      end else if (sh >= 26'sd31) begin
         exp_p = '0;
      end else begin
         exp_p = 32'(acc_last) >> sh[4:0];
      end

      if (setup.cfg_bad || setup.call_bad || (!setup.call_mode && uz_ff[LAST])) begin
         rsp_price_in = '0;
         rsp_status_in = STATUS_INVALID;
      end else if (setup.call_mode && uz_ff[LAST]) begin
         rsp_price_in = '0;
         rsp_status_in = setup.clamp ? STATUS_SAT : STATUS_OK;
      end else if (!setup.call_mode && setup.y_zero) begin
         rsp_price_in = setup.strike;
         rsp_status_in = setup.clamp ? STATUS_SAT : STATUS_OK;
      end else begin
         rsp_price_in = exp_p;
         rsp_status_in = (sat || setup.clamp) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_price_ff <= rsp_price_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_price_q16 = rsp_price_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // an invalid result never carries a price
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INVALID |-> rsp_price_q16 == 32'd0)
      else $error("invalid status with nonzero price");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_INVALID
                     || rsp_status == STATUS_SAT))
      else $error("undefined status code");

   // a saturated exp2 result is reported as saturated
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_price_q16 != 32'hFFFF_FFFF
      || !setup.call_mode || setup.cfg_bad)
      else $error("full-scale price reported as ok");
`endif

endmodule

// ===== verif/perpetual_american_option_price_test.sv =====
`timescale 1ns / 1ps

module perpetual_american_option_price_test;
   import pap_pkg::*;

   localparam int FRAC = 16;
   localparam int ITERS = 16;
   localparam int LATENCY = 38;
   localparam int WATCHDOG = 4000;
   localparam int RANDOM_ITEMS = 1550;

   typedef struct packed {
      logic [31:0] price;
      logic [1:0]  status;
   } quote_type;

   typedef struct {
      logic [31:0] underlying;
      logic        fixed;
      quote_type   quote;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_underlying_q16 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_price_q16;
   logic [1:0] rsp_status;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // pricing configuration as the block should hold it
   logic [15:0] rate_reg;
   logic [15:0] vol_reg;
   logic [31:0] strike_reg;
   logic [16:0] carry_reg;
   logic        call_reg;

   quote_type quotes_due[$];
   row_type rows[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit hold_off = 1'b0;

   perpetual_american_option_price #(
      .FRAC_BITS(FRAC),
      .APPROX_ITERATIONS(ITERS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_underlying_q16(req_underlying_q16),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_price_q16(rsp_price_q16),
      .rsp_status(rsp_status),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // append a predicted quote to the scoreboard
   function automatic void queue_quote(input quote_type q);
      quotes_due = {quotes_due, q};
   endfunction

   // append one stimulus row to the directed table
   function automatic void add_row(input logic [31:0] u, input bit fixed, input quote_type q);
      row_type rw;
      rw.underlying = u;
      rw.fixed = fixed;
      rw.quote = q;
      rows = {rows, rw};
   endfunction

   // arithmetic shift right rounding toward minus infinity
   function automatic longint shr_floor(input longint v, input int n);
      longint unsigned m;
      if (v >= 0) return longint'(longint'(v) >>> n);
      m = 64'(-v);
      return -longint'((m + ((64'd1 << n) - 1)) >> n);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 in Q24 of a nonzero integer
   function automatic longint log2_q24(input longint unsigned x);
      int p;
      longint unsigned m;
      longint unsigned frac;
      p = 63;
      frac = 0;
      while (x[p] == 1'b0) p--;
      m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
      for (int i = 1; i <= ITERS; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            if (i <= 24) frac = frac | (64'd1 << (24 - i));
         end
      end
      return longint'((64'(p) << 24) | frac);
   endfunction

   // 2^L with L in Q24, Q16 result, flags saturation
   function automatic longint unsigned exp2_q16(input longint lv, output bit sat);
      longint n;
      longint e;
      longint unsigned f;
      longint unsigned acc;
      longint unsigned s;
      n = shr_floor(lv, 24);
      f = 64'(lv) & 64'hFFFFFF;
      acc = 64'd1 << 30;
      s = 64'd1 << 31;
      sat = 1'b0;
      for (int i = 1; i <= ITERS; i++) begin
         s = int_sqrt(s << 30);
         if (i <= 24 && f[24 - i]) acc = (acc * s) >> 30;
      end
      if (n + FRAC >= 32) begin
         sat = 1'b1;
         return 64'hFFFFFFFF;
      end
      e = n + FRAC - 30;
      if (e >= 0) return acc << e;
      if (e <= -63) return 0;
      return acc >> (-e);
   endfunction

   function automatic quote_type option_price(input logic [31:0] u);
      quote_type q;
      bit clamp;
      bit sat;
      bit bneg;
      longint unsigned s2, babs, amag, c, dabs, root, num, den;
      longint a, d, y, lk, lnum, dl, lv;
      q = '0;
      clamp = 1'b0;
      sat = 1'b0;
      if (vol_reg == 0 || strike_reg == 0) begin
         q.status = STATUS_INVALID;
         return q;
      end
      s2 = 64'(vol_reg) * 64'(vol_reg);
      bneg = carry_reg[16];
      babs = bneg ? (64'h20000 - 64'(carry_reg)) : 64'(carry_reg);
      amag = (babs << 32) / s2;
      c = (64'(rate_reg) << 33) / s2;
      if (amag > (64'd1 << 30)) begin amag = 64'd1 << 30; clamp = 1'b1; end
      if (c > (64'd1 << 30)) begin c = 64'd1 << 30; clamp = 1'b1; end
      a = bneg ? -longint'(amag) : longint'(amag);
      d = a - 32768;
      dabs = d < 0 ? 64'(-d) : 64'(d);
      root = int_sqrt(dabs * dabs + (c << 16));
      y = call_reg ? (32768 - a + longint'(root)) : (32768 - a - longint'(root));
      if (y > (64'sd1 <<< 31)) begin y = 64'sd1 <<< 31; clamp = 1'b1; end
      if (y < -(64'sd1 <<< 31)) begin y = -(64'sd1 <<< 31); clamp = 1'b1; end
      if (call_reg && y <= 65536) begin
         q.status = STATUS_INVALID;
         return q;
      end
      if (!call_reg && u == 0) begin
         q.status = STATUS_INVALID;
         return q;
      end
      if (call_reg && u == 0) q.price = '0;
      else if (!call_reg && y == 0) q.price = strike_reg;
      else begin
         if (call_reg) begin
            num = 64'(y - 65536);
            den = 64'(y);
         end else begin
            den = 64'(-y);
            num = den + 65536;
         end
         lk = log2_q24(64'(strike_reg));
         lnum = log2_q24(num);
         dl = lnum - log2_q24(den) + log2_q24(64'(u)) - lk;
         lv = (lk - (longint'(FRAC) << 24)) - (lnum - (64'sd16 << 24))
            + shr_floor(y * dl, 16);
         q.price = 32'(exp2_q16(lv, sat));
      end
      q.status = (sat || clamp) ? STATUS_SAT : STATUS_OK;
      return q;
   endfunction

   // configuration write, mirrored in the predictor copy
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RATE: rate_reg = val[15:0];
         CSR_VOLATILITY: vol_reg = val[15:0];
         CSR_STRIKE: strike_reg = val;
         CSR_CARRY: carry_reg = val[16:0];
         CSR_IS_CALL: call_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic set_pricing(input logic [15:0] r, input logic [15:0] v,
                              input logic [31:0] k, input logic [16:0] b,
                              input logic cl);
      csr_write(CSR_RATE, 32'(r));
      csr_write(CSR_VOLATILITY, 32'(v));
      csr_write(CSR_STRIKE, k);
      csr_write(CSR_CARRY, 32'(b));
      csr_write(CSR_IS_CALL, 32'(cl));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (quotes_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // one request, predicted unless the table fixes the answer
   task automatic send_request(input logic [31:0] u, input bit fixed, input quote_type q);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_underlying_q16 <= u;
      queue_quote(fixed ? q : option_price(u));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_underlying();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($urandom_range(0, 65535));
         2: return strike_reg + 32'($urandom_range(0, 2000000)) - 32'd1000000;
         3: return 32'hFFFFFFFF - 32'($urandom_range(0, 15));
         default: return 32'($urandom_range(32768, 40000000));
      endcase
   endfunction

   // stimulus
   initial begin
      logic [31:0] u;
      int sent;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rate_reg = 16'd3277;
      vol_reg = 16'd13107;
      strike_reg = 32'd6553600;
      carry_reg = 17'd3277;
      call_reg = 1'b1;

      // directed table at reset settings: the call exponent lands on one
      add_row(32'd0, 1'b1, '{32'd0, STATUS_INVALID});
      add_row(32'hFFFFFFFF, 1'b0, '0);
      add_row(32'd1, 1'b0, '0);
      add_row(32'd6553600, 1'b0, '0);
      add_row(32'd65536, 1'b0, '0);
      add_row(32'h80000000, 1'b0, '0);
      foreach (rows[i]) send_request(rows[i].underlying, rows[i].fixed, rows[i].quote);
      drain();

      // put mode: zero base is invalid
      set_pricing(16'd3277, 16'd13107, 32'd6553600, 17'd3277, 1'b0);
      rows.delete();
      add_row(32'd0, 1'b1, '{32'd0, STATUS_INVALID});
      add_row(32'd1, 1'b0, '0);
      add_row(32'hFFFFFFFF, 1'b0, '0);
      add_row(32'd3000000, 1'b0, '0);
      foreach (rows[i]) send_request(rows[i].underlying, rows[i].fixed, rows[i].quote);
      drain();

      // zero volatility and zero strike
      set_pricing(16'd3277, 16'd0, 32'd6553600, 17'd3277, 1'b1);
      send_request(32'd65536, 1'b1, '{32'd0, STATUS_INVALID});
      drain();
      set_pricing(16'd3277, 16'd13107, 32'd0, 17'd3277, 1'b0);
      send_request(32'd65536, 1'b1, '{32'd0, STATUS_INVALID});
      drain();

      // put with zero exponent: rate zero, carry zero gives y = 0
      set_pricing(16'd0, 16'd13107, 32'd1234567, 17'd0, 1'b0);
      send_request(32'd65536, 1'b1, '{32'd1234567, STATUS_OK});
      drain();

      // call with y not above one (rate zero, positive carry)
      set_pricing(16'd0, 16'd13107, 32'd6553600, 17'd3277, 1'b1);
      send_request(32'd65536, 1'b1, '{32'd0, STATUS_INVALID});
      drain();

      // clamped extremes
      set_pricing(16'hFFFF, 16'd1, 32'hFFFFFFFF, 17'h10000, 1'b1);
      send_request(32'd65536, 1'b0, '0);
      send_request(32'hFFFFFFFF, 1'b0, '0);
      drain();
      set_pricing(16'hFFFF, 16'hFFFF, 32'd1, 17'h0FFFF, 1'b0);
      send_request(32'd1, 1'b0, '0);
      send_request(32'hFFFFFFFF, 1'b0, '0);
      drain();

      // random phases over a range of settings, with one long hold-off
      sent = 0;
      for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
         case (ph % 4)
            0: set_pricing(16'($urandom_range(0, 8000)), 16'($urandom_range(3000, 40000)),
                           32'($urandom_range(65536, 20000000)),
                           17'($urandom_range(0, 131071)), 1'($urandom()));
            1: set_pricing(16'($urandom()), 16'($urandom_range(1, 65535)), $urandom(),
                           17'($urandom()), 1'($urandom()));
            2: set_pricing(16'($urandom_range(1000, 6000)), 16'($urandom_range(6000, 30000)),
                           32'($urandom_range(1000000, 10000000)),
                           17'($urandom_range(0, 6000)), 1'b1);
            default: set_pricing(16'($urandom_range(1000, 6000)),
                                 16'($urandom_range(6000, 30000)),
                                 32'($urandom_range(1000000, 10000000)),
                                 17'($urandom_range(0, 6000)), 1'b0);
         endcase
         if (ph == 2) hold_off = 1'b1;
         for (int k = 0; k < 130 && sent < RANDOM_ITEMS; k++) begin
            u = random_underlying();
            send_request(u, 1'b0, '0);
            sent++;
         end
         hold_off = 1'b0;
         drain();
      end
      stim_done = 1'b1;
   end

   // response side: random stalls plus one long hold-off
   initial begin
      int gap;
      bit long_done;
      long_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !long_done) begin
            long_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare each response with the oldest predicted quote
   always @(posedge clock) begin
      quote_type q;
      if (!reset && rsp_valid && rsp_ready) begin
         if (quotes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response price %h status %0d", rsp_price_q16, rsp_status);
         end else begin
            q = quotes_due.pop_front();
            if (q.price !== rsp_price_q16 || q.status !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch price exp %h got %h status exp %0d got %0d",
                           q.price, rsp_price_q16, q.status, rsp_status);
            end
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("end of test: mismatches");
         $finish;
      end else if (stim_done) begin
         if (mismatches == 0 && quotes_due.size() == 0)
            $display("end of test: clean");
         else
            $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
